>>> rtl/core/fpba_pkg.sv
// ---------------------------------------------------------------------------
// Fixed partition allocator package
// Field widths, operation codes and the command and status types shared by
// the controller, the datapath and the top level.
// ---------------------------------------------------------------------------
package fpba_pkg;

    localparam int DEF_MAX_PARTITIONS = 16;
    localparam int DEF_SIZE_BITS      = 20;

    localparam int OP_BITS     = 2;
    localparam int SLOT_BITS   = 4;
    localparam int AMOUNT_BITS = 20;
    localparam int NUMBER_BITS = 5;
    localparam int COUNT_BITS  = 5;
    localparam int LEFT_BITS   = 20;
    localparam int TOTAL_BITS  = 24;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    localparam logic [OP_BITS-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_BITS-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_RELEASE = 2'd2;

    typedef struct packed {
        logic capture;
        logic apply;
        logic scan_issue;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic scan_empty;
    } dp_status_t;

endpackage

>>> rtl/core/fixed_partition_best_fit_allocator.sv
// ---------------------------------------------------------------------------
// Fixed partition best-fit allocator
// Loads, allocates and releases fixed memory partitions and reports the
// chosen partition together with the free and internal-fragment totals.
// ---------------------------------------------------------------------------
// After an accepted request the controller applies the table update, scans the
// n active table entries, where n is the active partition count, and writes the
// result register; the scan is skipped when n is zero. The scan reads one table
// entry per cycle, and a new request is taken only once the result is written;
// a result not yet taken holds the controller until the result register is free.
// Reset clears the used marks, the partition count and all control state; the
// size table holds no defined value until loaded and gets no clearing pass.
module fixed_partition_best_fit_allocator
    import fpba_pkg::*;
#(
    parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
    parameter int SIZE_BITS      = DEF_SIZE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_wdata,  // partition_count
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,    // slot_index, amount, release_number
    input  logic [OP_BITS-1:0]    s_tuser,    // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata,    // partition_number, leftover,
                                              // free_total, internal_total
    output logic                  m_tuser     // granted
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    logic [NUMBER_BITS-1:0] res_number;
    logic [LEFT_BITS-1:0]   res_leftover;
    logic [TOTAL_BITS-1:0]  res_free_total;
    logic [TOTAL_BITS-1:0]  res_internal_total;

    fpba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fpba_datapath #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .op                 (s_tuser),
        .slot_index         (s_tdata[3:0]),
        .amount             (s_tdata[23:4]),
        .release_number     (s_tdata[28:24]),
        .cmd                (cmd),
        .status             (status),
        .res_granted        (m_tuser),
        .res_number         (res_number),
        .res_leftover       (res_leftover),
        .res_free_total     (res_free_total),
        .res_internal_total (res_internal_total)
    );

    assign m_tdata = {7'd0, res_internal_total, res_free_total, res_leftover, res_number};

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while a request is in progress");

    a_result_ends_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result posted before the controller returned to idle");

    a_refused_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[24:0] == 25'd0))
        else $error("refused request carries a partition or leftover");

endmodule

>>> rtl/core/fpba_ctrl.sv
// ---------------------------------------------------------------------------
// Fixed partition allocator controller
// Sequences one request: capture, table update, table scan, result write.
// ---------------------------------------------------------------------------
module fpba_ctrl
    import fpba_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = status.scan_empty ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.finish    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

>>> rtl/core/fpba_datapath.sv
// ---------------------------------------------------------------------------
// Fixed partition allocator datapath
// Partition size and fragment memories, used marks, the best-fit scan with
// running totals, and the result register.
// ---------------------------------------------------------------------------
module fpba_datapath
    import fpba_pkg::*;
#(
    parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
    parameter int SIZE_BITS      = DEF_SIZE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [COUNT_BITS-1:0]  cfg_wdata,
    input  logic [OP_BITS-1:0]     op,
    input  logic [SLOT_BITS-1:0]   slot_index,
    input  logic [AMOUNT_BITS-1:0] amount,
    input  logic [NUMBER_BITS-1:0] release_number,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    output logic                   res_granted,
    output logic [NUMBER_BITS-1:0] res_number,
    output logic [LEFT_BITS-1:0]   res_leftover,
    output logic [TOTAL_BITS-1:0]  res_free_total,
    output logic [TOTAL_BITS-1:0]  res_internal_total
);

    localparam int IDX_BITS  = $clog2(MAX_PARTITIONS);
    localparam int CNT_BITS  = $clog2(MAX_PARTITIONS + 1);
    localparam int WIDE_BITS = (SIZE_BITS > AMOUNT_BITS) ? SIZE_BITS : AMOUNT_BITS;
    localparam int SUM_BITS  = SIZE_BITS + CNT_BITS;
    localparam int SAT_BITS  = (SUM_BITS > TOTAL_BITS) ? SUM_BITS : TOTAL_BITS;
    localparam int NUM_BITS  = (IDX_BITS + 1 > NUMBER_BITS) ? IDX_BITS + 1 : NUMBER_BITS;

    logic [COUNT_BITS-1:0]  count_reg;
    logic [OP_BITS-1:0]     op_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [AMOUNT_BITS-1:0] amount_reg;
    logic [NUMBER_BITS-1:0] rel_reg;
    logic                   ok_reg;

    logic [MAX_PARTITIONS-1:0] used_reg;
    logic [SIZE_BITS-1:0]      size_mem [MAX_PARTITIONS];
    logic [SIZE_BITS-1:0]      frag_mem [MAX_PARTITIONS];
    logic [SIZE_BITS-1:0]      size_rd_reg;
    logic [SIZE_BITS-1:0]      frag_rd_reg;

    logic [CNT_BITS-1:0]  addr_reg;
    logic                 rd_valid_reg;
    logic [IDX_BITS-1:0]  rd_idx_reg;
    logic [SUM_BITS-1:0]  free_acc_reg;
    logic [SUM_BITS-1:0]  frag_acc_reg;
    logic                 found_reg;
    logic [IDX_BITS-1:0]  best_idx_reg;
    logic [SIZE_BITS-1:0] best_size_reg;

    logic [CNT_BITS-1:0]  active_n;
    logic [IDX_BITS-1:0]  addr_idx;
    logic [IDX_BITS-1:0]  load_idx;
    logic [IDX_BITS-1:0]  rel_idx;
    logic                 load_ok;
    logic                 rel_ok;
    logic [WIDE_BITS-1:0] amount_wide;
    logic [WIDE_BITS-1:0] rd_size_wide;
    logic                 fits;
    logic                 better;
    logic                 alloc_hit;
    logic [WIDE_BITS-1:0] left_wide;
    logic [SIZE_BITS-1:0] frag_new;
    logic [SUM_BITS-1:0]  free_fin;
    logic [SUM_BITS-1:0]  frag_fin;
    logic [SAT_BITS-1:0]  free_ext;
    logic [SAT_BITS-1:0]  frag_ext;
    logic [NUM_BITS-1:0]  best_num;
    logic [NUMBER_BITS-1:0] number_sel;

    assign active_n = (int'(count_reg) > MAX_PARTITIONS) ? CNT_BITS'(MAX_PARTITIONS)
                                                         : CNT_BITS'(count_reg);
    assign addr_idx = addr_reg[IDX_BITS-1:0];
    assign load_idx = IDX_BITS'(slot_reg);
    assign rel_idx  = IDX_BITS'(rel_reg - NUMBER_BITS'(1));
    assign load_ok  = int'(slot_reg) < MAX_PARTITIONS;
    assign rel_ok   = (rel_reg != '0) && (int'(rel_reg) <= int'(active_n))
                      && used_reg[rel_idx];

    assign amount_wide  = WIDE_BITS'(amount_reg);
    assign rd_size_wide = WIDE_BITS'(size_rd_reg);
    assign fits         = rd_size_wide >= amount_wide;
    assign better       = !found_reg || (size_rd_reg < best_size_reg);

    assign alloc_hit = (op_reg == OP_ALLOC) && found_reg;
    assign left_wide = WIDE_BITS'(best_size_reg) - amount_wide;
    assign frag_new  = left_wide[SIZE_BITS-1:0];
    assign free_fin  = free_acc_reg - (alloc_hit ? SUM_BITS'(best_size_reg) : '0);
    assign frag_fin  = frag_acc_reg + (alloc_hit ? SUM_BITS'(frag_new) : '0);
    assign free_ext  = SAT_BITS'(free_fin);
    assign frag_ext  = SAT_BITS'(frag_fin);
    assign best_num  = NUM_BITS'(best_idx_reg) + NUM_BITS'(1);

    assign status.scan_empty = (active_n == '0);
    assign status.scan_last  = (addr_reg + CNT_BITS'(1)) == active_n;

    always_comb begin
        case (op_reg)
            OP_LOAD:    number_sel = ok_reg ? NUMBER_BITS'(slot_reg) + NUMBER_BITS'(1) : '0;
            OP_ALLOC:   number_sel = found_reg ? best_num[NUMBER_BITS-1:0] : '0;
            OP_RELEASE: number_sel = ok_reg ? rel_reg : '0;
            default:    number_sel = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            used_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
            if (cmd.apply) begin
                if (op_reg == OP_LOAD && load_ok) begin
                    used_reg[load_idx] <= 1'b0;
                end
                if (op_reg == OP_RELEASE && rel_ok) begin
                    used_reg[rel_idx] <= 1'b0;
                end
            end
            if (cmd.finish && alloc_hit) begin
                used_reg[best_idx_reg] <= 1'b1;
            end
            rd_valid_reg <= cmd.scan_issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= op;
            slot_reg   <= slot_index;
            amount_reg <= amount;
            rel_reg    <= release_number;
        end
        if (cmd.apply) begin
            ok_reg       <= ((op_reg == OP_LOAD) && load_ok)
                            || ((op_reg == OP_RELEASE) && rel_ok);
            addr_reg     <= '0;
            free_acc_reg <= '0;
            frag_acc_reg <= '0;
            found_reg    <= 1'b0;
        end else if (cmd.scan_issue) begin
            addr_reg <= addr_reg + CNT_BITS'(1);
        end
        rd_idx_reg <= addr_idx;
        if (rd_valid_reg) begin
            if (used_reg[rd_idx_reg]) begin
                frag_acc_reg <= frag_acc_reg + SUM_BITS'(frag_rd_reg);
            end else begin
                free_acc_reg <= free_acc_reg + SUM_BITS'(size_rd_reg);
                if (op_reg == OP_ALLOC && fits && better) begin
                    found_reg     <= 1'b1;
                    best_idx_reg  <= rd_idx_reg;
                    best_size_reg <= size_rd_reg;
                end
            end
        end
        if (cmd.finish) begin
            res_granted        <= alloc_hit || ok_reg;
            res_number         <= number_sel;
            res_leftover       <= alloc_hit ? left_wide[LEFT_BITS-1:0] : '0;
            res_free_total     <= (free_ext > SAT_BITS'(TOTAL_MAX)) ? TOTAL_MAX
                                                                    : free_ext[TOTAL_BITS-1:0];
            res_internal_total <= (frag_ext > SAT_BITS'(TOTAL_MAX)) ? TOTAL_MAX
                                                                    : frag_ext[TOTAL_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply && op_reg == OP_LOAD && load_ok) begin
            size_mem[load_idx] <= amount_wide[SIZE_BITS-1:0];
        end
        size_rd_reg <= size_mem[addr_idx];
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && alloc_hit) begin
            frag_mem[best_idx_reg] <= frag_new;
        end
        frag_rd_reg <= frag_mem[addr_idx];
    end

endmodule
